// ===== rtl/core/smsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// smsgd_pkg: shared definitions of the softmax classifier core
// Sizes, operation and register codes, the exp table and address helper.
// ----------------------------------------------------------------------------
package smsgd_pkg;

   localparam int NUM_CLASSES = 10;
   localparam int FEATURE_DIM = 1024;

   localparam int CNT_W   = $clog2(NUM_CLASSES);
   localparam int EL_W    = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
   localparam int ELC_W   = $clog2(FEATURE_DIM + 1);
   localparam int WADDR_W = $clog2(NUM_CLASSES * FEATURE_DIM);

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;
   localparam int ACC_W      = 48;
   localparam int SUM_W      = 36;

   typedef enum logic [1:0] {
      OP_FEATURE = 2'd0,
      OP_WRITE   = 2'd1,
      OP_READ    = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   localparam logic REG_LEARN_ENABLE  = 1'b0;
   localparam logic REG_LEARNING_RATE = 1'b1;

   localparam logic [15:0] LEARNING_RATE_RESET = 16'd655;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [16:0] ONE_Q16   = 17'd65536;

   // 2^(-k/16) in Q.16, k = 0..16.
   localparam logic [16:0] POW2_TAB [17] = '{
      17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
      17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
      17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
   };

   function automatic logic [WADDR_W-1:0] waddr(input logic [3:0] c, input logic [9:0] e);
      return WADDR_W'(32'(c) * FEATURE_DIM + 32'(e));
   endfunction

endpackage

// ===== rtl/core/smsgd_ram.sv =====
// ----------------------------------------------------------------------------
// smsgd_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smsgd_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/smsgd_exp.sv =====
// ----------------------------------------------------------------------------
// smsgd_exp: table based exp of a non-positive score difference
// Three stage pipeline giving exp(-d) in unsigned Q1.31 with a class tag.
// ----------------------------------------------------------------------------
module smsgd_exp
   import smsgd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [CNT_W-1:0] in_tag,
   input  logic [ACC_W-1:0] in_negd,
   output logic             out_valid,
   output logic [CNT_W-1:0] out_tag,
   output logic [31:0]      out_exp
);

   logic             v0_ff, v1_ff, v2_ff;
   logic [CNT_W-1:0] tag0_ff, tag1_ff, tag2_ff;
   logic             big_ff, zero_ff;
   logic [21:0]      t_ff;
   logic [16:0]      tk_ff;
   logic [23:0]      prod_ff;
   logic [4:0]       n_ff;
   logic [31:0]      exp_ff;

   logic [37:0] m;
   logic [3:0]  k;
   logic [16:0] diff;
   logic [16:0] v;

   always_comb begin
      m    = 38'(in_negd[20:0]) * 38'(LOG2E_Q16);
      k    = t_ff[15:12];
      diff = POW2_TAB[k] - POW2_TAB[5'(k) + 5'd1];
      v    = tk_ff - 17'(prod_ff[23:12]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      tag0_ff <= in_tag;
      big_ff  <= (in_negd >= ACC_W'(32'd32 << 16));
      t_ff    <= m[37:16];
      tag1_ff <= tag0_ff;
      zero_ff <= big_ff || (t_ff[21:16] >= 6'd32);
      n_ff    <= t_ff[20:16];
      tk_ff   <= POW2_TAB[k];
      prod_ff <= diff[11:0] * t_ff[11:0];
      tag2_ff <= tag1_ff;
      exp_ff  <= zero_ff ? 32'd0 : ({v, 15'd0} >> n_ff);
   end

   assign out_valid = v2_ff;
   assign out_tag   = tag2_ff;
   assign out_exp   = exp_ff;

endmodule

// ===== rtl/core/smsgd_div.sv =====
// ----------------------------------------------------------------------------
// smsgd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smsgd_div
   import smsgd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACC_W-1:0] dividend,
   input  logic [SUM_W-1:0] divisor,
   output logic             done,
   output logic [ACC_W-1:0] quotient
);

   logic             busy_ff, done_ff;
   logic [5:0]       bit_ff;
   logic [ACC_W-1:0] dvd_ff, q_ff;
   logic [SUM_W-1:0] dvs_ff;
   logic [SUM_W:0]   rem_ff;

   logic [SUM_W:0]   rem_sh;
   logic             take;

   always_comb begin
      rem_sh = {rem_ff[SUM_W-1:0], dvd_ff[ACC_W-1]};
      take   = (rem_sh >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            bit_ff  <= 6'd0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            q_ff    <= '0;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[ACC_W-2:0], 1'b0};
            rem_ff <= take ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
            q_ff   <= {q_ff[ACC_W-2:0], take};
            bit_ff <= bit_ff + 6'd1;
            if (bit_ff == 6'(ACC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/core/softmax_classifier_sgd_core.sv =====
// ----------------------------------------------------------------------------
// softmax_classifier_sgd_core: softmax classifier with online SGD training
// Weight memory centered sequencer: dot products, exp, normalization, update.
// ----------------------------------------------------------------------------
// Usage. Items enter on the req_ stream. An op of feature element stores the
// element and multiplies it by its weight in every class's row; the transfer
// that carries tlast, or that fills the last feature position, closes the
// sample. A closed sample yields NUM_CLASSES results on the rsp_ stream, one
// per class from class 0 up, with tlast on the final one. Weight write ops
// give no result; weight read ops give one result with tlast set.
// Sequencing. A feature element is bounded by the one read port of the weight
// memory, which serves one class per cycle. Closing a sample then finds the
// maximum score, takes the exp of every class, runs the iterative divider
// once per class and emits the results. With learning on, each class then
// walks its weight row at one element per cycle. A weight read passes
// through ST_RD_WAIT and ST_RD_OUT.
// Stalls. The result sits in an output register; while the receiver holds
// rsp_tready low the sequencer waits on its next result, and req_tready is
// low whenever the sequencer is busy. Reset clears the sample progress, the
// accumulators and the configuration registers; the weight memory holds
// undefined data until written. The csr_ port is always ready.
module softmax_classifier_sgd_core
   import smsgd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata from bit 0: feature[15:0], label[19:16], class_index[23:20],
   // element_index[33:24], weight_value[65:34], zero padding [71:66].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: op[1:0].
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata from bit 0: class_id[3:0], probability[19:4], best_class[23:20],
   // weight_read[55:24].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [15:0]           csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_WAIT, ST_RD_OUT, ST_MAC, ST_MAX, ST_EXP, ST_DIV_START,
      ST_DIV_WAIT, ST_EMIT, ST_GRAD, ST_UPD, ST_CLEAR
   } state_type;

   // Request fields.
   op_type             in_op;
   logic signed [15:0] in_feature;
   logic [3:0]         in_label, in_ci;
   logic [9:0]         in_ei;
   logic [31:0]        in_wv;
   logic               req_fire;

   assign in_op      = op_type'(req_tuser);
   assign in_feature = req_tdata[15:0];
   assign in_label   = req_tdata[19:16];
   assign in_ci      = req_tdata[23:20];
   assign in_ei      = req_tdata[33:24];
   assign in_wv      = req_tdata[65:34];

   state_type state_ff;

   // Configuration.
   logic        learn_ff;
   logic [15:0] rate_ff;

   // Sample bookkeeping.
   logic [ELC_W-1:0]   count_ff;
   logic [EL_W-1:0]    e_ff;
   logic signed [15:0] x_ff;
   logic [3:0]         label_ff;
   logic               fin_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               iss_on_ff;

   // Class state.
   logic signed [ACC_W-1:0] acc_ff [NUM_CLASSES];
   logic [31:0]             exps_ff [NUM_CLASSES];
   logic [15:0]             prob_ff [NUM_CLASSES];
   logic signed [ACC_W-1:0] zmax_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [CNT_W-1:0]        best_ff;
   logic [15:0]             bestp_ff;

   // Dot product pipeline.
   logic                    s1_v_ff, p_v_ff;
   logic [CNT_W-1:0]        s1_c_ff, p_c_ff;
   logic signed [47:0]      prod_ff;

   // Update pipeline.
   logic signed [34:0]      g_ff;
   logic [EL_W-1:0]         ue_ff, u1_e_ff, u2_e_ff;
   logic                    u1_v_ff, u2_v_ff;
   logic signed [50:0]      uprod_ff;
   logic signed [31:0]      uw_ff;

   // Weight read results.
   logic             rd_ok_ff;
   logic [3:0]       rd_ci_ff;
   logic [31:0]      rdw_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;
   logic                  out_free;

   // Memories and units.
   logic               w_wr_en;
   logic [WADDR_W-1:0] w_wr_addr, w_rd_addr;
   logic [31:0]        w_wr_data, w_rd_data;
   logic               f_wr_en;
   logic [EL_W-1:0]    f_wr_addr, e_now;
   logic [15:0]        f_rd_data;

   logic               exp_out_v;
   logic [CNT_W-1:0]   exp_out_tag;
   logic [31:0]        exp_out;
   logic               div_done;
   logic [ACC_W-1:0]   div_q;

   logic [CNT_W-1:0]        acc_idx;
   logic signed [ACC_W-1:0] acc_rd;
   logic signed [ACC_W:0]   acc_sum;
   logic signed [ACC_W-1:0] acc_next;
   logic signed [35:0]      nw;
   logic signed [31:0]      nw_sat;
   logic signed [17:0]      pdiff;
   logic [15:0]             p_sat;
   logic                    rd_in_range;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      e_now = (count_ff >= ELC_W'(FEATURE_DIM)) ? EL_W'(FEATURE_DIM - 1)
                                                : count_ff[EL_W-1:0];
      rd_in_range = (32'(in_ci) < NUM_CLASSES) && (32'(in_ei) < FEATURE_DIM);

      acc_idx = (state_ff == ST_MAC) ? p_c_ff : cnt_ff;
      acc_rd  = acc_ff[acc_idx];
      acc_sum = {acc_rd[ACC_W-1], acc_rd} + (ACC_W+1)'(prod_ff >>> 16);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                   : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_next = acc_sum[ACC_W-1:0];
      end

      nw = 36'(uw_ff) - 36'(uprod_ff >>> 16);
      if (nw > 36'sd2147483647) begin
         nw_sat = 32'sh7FFFFFFF;
      end else if (nw < -36'sd2147483648) begin
         nw_sat = 32'sh80000000;
      end else begin
         nw_sat = nw[31:0];
      end

      pdiff = $signed({2'b00, prob_ff[cnt_ff]})
            - ((label_ff == 4'(cnt_ff)) ? $signed({1'b0, ONE_Q16}) : 18'sd0);
      p_sat = (div_q > ACC_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];

      w_wr_en   = 1'b0;
      w_wr_addr = waddr(in_ci, in_ei);
      w_wr_data = in_wv;
      w_rd_addr = waddr(in_ci, in_ei);
      case (state_ff)
         ST_IDLE: begin
            w_wr_en = req_fire && (in_op == OP_WRITE) && rd_in_range;
         end
         ST_MAC: begin
            w_rd_addr = waddr(4'(cnt_ff), 10'(e_ff));
         end
         ST_UPD: begin
            w_rd_addr = waddr(4'(cnt_ff), 10'(ue_ff));
            w_wr_en   = u2_v_ff;
            w_wr_addr = waddr(4'(cnt_ff), 10'(u2_e_ff));
            w_wr_data = nw_sat;
         end
         default: begin
         end
      endcase

      f_wr_en   = req_fire && (in_op == OP_FEATURE);
      f_wr_addr = e_now;
   end

   smsgd_ram #(.DEPTH(NUM_CLASSES * FEATURE_DIM), .WIDTH(32), .AW(WADDR_W)) u_weights (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   smsgd_ram #(.DEPTH(FEATURE_DIM), .WIDTH(16), .AW(EL_W)) u_features (
      .clock   (clock),
      .wr_en   (f_wr_en),
      .wr_addr (f_wr_addr),
      .wr_data (in_feature),
      .rd_addr (ue_ff),
      .rd_data (f_rd_data)
   );

   smsgd_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  ((state_ff == ST_EXP) && iss_on_ff),
      .in_tag    (cnt_ff),
      .in_negd   (ACC_W'(zmax_ff - acc_rd)),
      .out_valid (exp_out_v),
      .out_tag   (exp_out_tag),
      .out_exp   (exp_out)
   );

   smsgd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIV_START),
      .dividend ({exps_ff[cnt_ff], 16'd0}),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer: state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         learn_ff     <= 1'b0;
         rate_ff      <= LEARNING_RATE_RESET;
         count_ff     <= '0;
         iss_on_ff    <= 1'b0;
         s1_v_ff      <= 1'b0;
         p_v_ff       <= 1'b0;
         u1_v_ff      <= 1'b0;
         u2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_LEARN_ENABLE:  learn_ff <= csr_data[0];
               REG_LEARNING_RATE: rate_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Dot product pipeline, active only in ST_MAC.
         s1_v_ff <= (state_ff == ST_MAC) && iss_on_ff;
         s1_c_ff <= cnt_ff;
         p_v_ff  <= s1_v_ff;
         p_c_ff  <= s1_c_ff;
         prod_ff <= $signed(w_rd_data) * x_ff;

         // Update pipeline, active only in ST_UPD.
         u1_v_ff  <= (state_ff == ST_UPD) && iss_on_ff;
         u1_e_ff  <= ue_ff;
         u2_v_ff  <= u1_v_ff;
         u2_e_ff  <= u1_e_ff;
         uprod_ff <= g_ff * $signed(f_rd_data);
         uw_ff    <= w_rd_data;

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (in_op)
                     OP_FEATURE: begin
                        e_ff      <= e_now;
                        x_ff      <= in_feature;
                        label_ff  <= in_label;
                        count_ff  <= ELC_W'(e_now) + ELC_W'(1);
                        fin_ff    <= req_tlast ||
                                     (32'(e_now) + 1 >= FEATURE_DIM);
                        cnt_ff    <= '0;
                        iss_on_ff <= 1'b1;
                        state_ff  <= ST_MAC;
                     end
                     OP_READ: begin
                        rd_ok_ff <= rd_in_range;
                        rd_ci_ff <= in_ci;
                        state_ff <= ST_RD_WAIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_RD_WAIT: begin
               rdw_ff   <= rd_ok_ff ? w_rd_data : 32'd0;
               state_ff <= ST_RD_OUT;
            end
            ST_RD_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {rdw_ff, 4'd0, 16'd0, rd_ci_ff};
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_MAC: begin
               if (iss_on_ff) begin
                  if (cnt_ff == CNT_W'(NUM_CLASSES - 1)) begin
                     iss_on_ff <= 1'b0;
                  end else begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                  end
               end
               if (p_v_ff) begin
                  acc_ff[p_c_ff] <= acc_next;
                  if (p_c_ff == CNT_W'(NUM_CLASSES - 1)) begin
                     cnt_ff   <= '0;
                     state_ff <= fin_ff ? ST_MAX : ST_IDLE;
                  end
               end
            end
            ST_MAX: begin
               if ((cnt_ff == '0) || (acc_rd > zmax_ff)) begin
                  zmax_ff <= acc_rd;
               end
               if (cnt_ff == CNT_W'(NUM_CLASSES - 1)) begin
                  cnt_ff    <= '0;
                  sum_ff    <= '0;
                  iss_on_ff <= 1'b1;
                  state_ff  <= ST_EXP;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_EXP: begin
               if (iss_on_ff) begin
                  if (cnt_ff == CNT_W'(NUM_CLASSES - 1)) begin
                     iss_on_ff <= 1'b0;
                  end else begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                  end
               end
               if (exp_out_v) begin
                  exps_ff[exp_out_tag] <= exp_out;
                  sum_ff <= sum_ff + SUM_W'(exp_out);
                  if (exp_out_tag == CNT_W'(NUM_CLASSES - 1)) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_DIV_START;
                  end
               end
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  prob_ff[cnt_ff] <= p_sat;
                  if ((cnt_ff == '0) || (p_sat > bestp_ff)) begin
                     best_ff  <= cnt_ff;
                     bestp_ff <= p_sat;
                  end
                  if (cnt_ff == CNT_W'(NUM_CLASSES - 1)) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_EMIT;
                  end else begin
                     cnt_ff   <= cnt_ff + CNT_W'(1);
                     state_ff <= ST_DIV_START;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {32'd0, 4'(best_ff), prob_ff[cnt_ff], 4'(cnt_ff)};
                  rsp_last_ff  <= (cnt_ff == CNT_W'(NUM_CLASSES - 1));
                  if (cnt_ff == CNT_W'(NUM_CLASSES - 1)) begin
                     cnt_ff   <= '0;
                     state_ff <= learn_ff ? ST_GRAD : ST_CLEAR;
                  end else begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                  end
               end
            end
            ST_GRAD: begin
               g_ff      <= $signed({1'b0, rate_ff}) * pdiff;
               ue_ff     <= '0;
               iss_on_ff <= 1'b1;
               state_ff  <= ST_UPD;
            end
            ST_UPD: begin
               if (iss_on_ff) begin
                  if (ELC_W'(ue_ff) + ELC_W'(1) == count_ff) begin
                     iss_on_ff <= 1'b0;
                  end else begin
                     ue_ff <= ue_ff + EL_W'(1);
                  end
               end
               if (u2_v_ff && (ELC_W'(u2_e_ff) + ELC_W'(1) == count_ff)) begin
                  if (cnt_ff == CNT_W'(NUM_CLASSES - 1)) begin
                     state_ff <= ST_CLEAR;
                  end else begin
                     cnt_ff   <= cnt_ff + CNT_W'(1);
                     state_ff <= ST_GRAD;
                  end
               end
            end
            ST_CLEAR: begin
               count_ff <= '0;
               for (int i = 0; i < NUM_CLASSES; i++) begin
                  acc_ff[i] <= '0;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/smsgd_checker.sv =====
// ----------------------------------------------------------------------------
// smsgd_checker: port level checks of the classifier core
// Watches the result stream over time; bound to the top level.
// ----------------------------------------------------------------------------
module smsgd_checker
   import smsgd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The best class always names an existing class.
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[23:20]) < NUM_CLASSES))
      else $error("best class out of range");

   // Nonzero weight data appears only on a result with tlast set.
   a_read_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[55:24] != 32'd0) |-> rsp_tlast)
      else $error("weight data on a non-final result");

   // The core takes no item while it has just started a weight read.
   a_busy_read: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_READ) |=> !req_tready)
      else $error("item accepted during a weight read");

endmodule

bind softmax_classifier_sgd_core smsgd_checker u_smsgd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
